### rtl/rle_vector_range_decoder_unit_assert.svh
// Assertion macros shared by the run-length vector range decoder modules.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef RLE_VECTOR_RANGE_DECODER_UNIT_ASSERT_SVH
`define RLE_VECTOR_RANGE_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RVRD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rvrd assertion failed");

// Next-cycle implication, checked out of reset.
`define RVRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rvrd assertion failed");

`endif

### rtl/rvrd_pkg.sv
// Package for the run-length vector range decoder: field widths, default
// parameters, command and state codes, controller/datapath interface structs.
`timescale 1ns / 1ps

package rvrd_pkg;

  localparam int MAX_RUNS_DEF    = 4096;
  localparam int VECTOR_SIZE_DEF = 1024;
  localparam int VALUE_WIDTH_DEF = 64;

  localparam int CMD_W       = 2;
  localparam int LEN_W       = 32;
  localparam int OUT_VALUE_W = 64;
  localparam int VINDEX_W    = 22;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_START  = 2'd2,
    CMD_FETCH  = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEK_RD,
    ST_SEEK_CHK,
    ST_FETCH,
    ST_FILL
  } state_t;

  // Outcome of evaluating a fetch against the current run.
  typedef enum logic [1:0] {
    EV_DONE,
    EV_SKIP,
    EV_MISS
  } eval_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic seek_init;
    logic seek_step;
    logic cache_fill;
    logic fetch_step;
  } dp_cmd_t;

  typedef struct packed {
    logic  slot_free;
    eval_t eval;
    logic  seek_found;
    logic  seek_end;
    logic  table_empty;
  } dp_sts_t;

endpackage

### rtl/rvrd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rvrd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/rvrd_ctrl.sv
// Controller state machine of the run-length vector range decoder.
// Depends on rvrd_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "rle_vector_range_decoder_unit_assert.svh"

module rvrd_ctrl
  import rvrd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_stall,
  input  dp_sts_t          sts_i,
  output dp_cmd_t          cmd_o
);

  state_t   state_r;
  state_t   state_nxt;
  command_t cmd_code;

  assign cmd_code = command_t'(in_command);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (cmd_code)
            CMD_CLEAR:  cmd_o.clear  = 1'b1;
            CMD_APPEND: cmd_o.append = 1'b1;
            CMD_START: begin
              cmd_o.seek_init = 1'b1;
              // empty table resolves at once
              if (!sts_i.table_empty) begin
                state_nxt = ST_SEEK_RD;
              end
            end
            CMD_FETCH: begin
              if (sts_i.eval == EV_DONE && sts_i.slot_free) begin
                cmd_o.fetch_step = 1'b1;
              end else begin
                state_nxt = ST_FETCH;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SEEK_RD: begin
        state_nxt = ST_SEEK_CHK;
      end
      ST_SEEK_CHK: begin
        cmd_o.seek_step = 1'b1;
        if (sts_i.seek_found || sts_i.seek_end) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SEEK_RD;
        end
      end
      ST_FETCH: begin
        unique case (sts_i.eval)
          EV_MISS: state_nxt = ST_FILL;
          EV_SKIP: cmd_o.fetch_step = 1'b1;
          EV_DONE: begin
            // hold until the output register can take the transaction
            if (sts_i.slot_free) begin
              cmd_o.fetch_step = 1'b1;
              state_nxt        = ST_IDLE;
            end
          end
          default: state_nxt = ST_FETCH;
        endcase
      end
      ST_FILL: begin
        cmd_o.cache_fill = 1'b1;
        state_nxt        = ST_FETCH;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `RVRD_ASSERT_NEXT(a_seek_rd_then_chk, state_r == ST_SEEK_RD, state_r == ST_SEEK_CHK)
  `RVRD_ASSERT_NEXT(a_fill_then_fetch, state_r == ST_FILL, state_r == ST_FETCH)
  `RVRD_ASSERT_IMPL(a_no_step_on_miss, cmd_o.fetch_step, sts_i.eval != EV_MISS)

endmodule

### rtl/rvrd_datapath.sv
// Datapath of the run-length vector range decoder: run tables, seek walker,
// current-run cache and output register. Depends on rvrd_pkg, rvrd_ram and
// the shared assertion macro header.
`timescale 1ns / 1ps
`include "rle_vector_range_decoder_unit_assert.svh"

module rvrd_datapath
  import rvrd_pkg::*;
#(
  parameter int MAX_RUNS    = MAX_RUNS_DEF,
  parameter int VECTOR_SIZE = VECTOR_SIZE_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd_i,
  output dp_sts_t                sts_o,
  input  logic [LEN_W-1:0]       in_run_length,
  input  logic [OUT_VALUE_W-1:0] in_run_value,
  input  logic [VINDEX_W-1:0]    in_vector_index,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUT_VALUE_W-1:0] out_value,
  output logic                   out_valid_res,
  output logic                   out_last,
  output logic                   out_out_of_range,
  output logic                   out_table_overflow
);

  localparam int IDX_W = $clog2(MAX_RUNS);
  localparam int CNT_W = $clog2(MAX_RUNS + 1);
  localparam int EL_W  = $clog2(VECTOR_SIZE + 1);
  localparam int POS_W = LEN_W + CNT_W;
  localparam int TGT_W = VINDEX_W + EL_W;
  localparam int ACC_W = (POS_W > TGT_W) ? POS_W : TGT_W;

  // control state
  logic [CNT_W-1:0] runs_loaded_r, runs_loaded_nxt;
  logic [CNT_W-1:0] current_run_r, current_run_nxt;
  logic [LEN_W-1:0] offset_r, offset_nxt;
  logic [EL_W-1:0]  elements_left_r, elements_left_nxt;
  logic             range_flag_r, range_flag_nxt;
  logic             overflow_flag_r, overflow_flag_nxt;
  logic             cache_vld_r, cache_vld_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload
  logic [ACC_W-1:0]       pos_r, pos_nxt;
  logic [ACC_W-1:0]       target_r, target_nxt;
  logic [LEN_W-1:0]       cur_len_r, cur_len_nxt;
  logic [VALUE_WIDTH-1:0] cur_val_r, cur_val_nxt;
  logic [OUT_VALUE_W-1:0] out_value_r, out_value_nxt;
  logic                   out_valid_res_r, out_valid_res_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_range_r, out_range_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  logic [LEN_W-1:0]       rd_len;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic                   table_full;
  logic                   wr_en;
  logic [CNT_W-1:0]       run_inc;
  logic [ACC_W-1:0]       pos_sum;
  logic                   seek_found;
  logic                   seek_end;
  logic                   slot_free;
  eval_t                  eval;
  logic                   res_valid;
  logic [VALUE_WIDTH-1:0] res_val;
  logic                   emit;

  assign table_full = (runs_loaded_r == CNT_W'(MAX_RUNS));
  assign wr_en      = cmd_i.append && !table_full;
  assign run_inc    = current_run_r + CNT_W'(1);
  assign pos_sum    = pos_r + ACC_W'(rd_len);
  assign seek_found = (pos_sum > target_r);
  assign seek_end   = (run_inc == runs_loaded_r);
  assign slot_free  = !out_valid_r || !out_stall;

  rvrd_ram #(
    .WIDTH(LEN_W),
    .DEPTH(MAX_RUNS)
  ) u_len_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(runs_loaded_r[IDX_W-1:0]),
    .wr_data(in_run_length),
    .rd_addr(current_run_r[IDX_W-1:0]),
    .rd_data(rd_len)
  );

  rvrd_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(MAX_RUNS)
  ) u_val_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(runs_loaded_r[IDX_W-1:0]),
    .wr_data(in_run_value[VALUE_WIDTH-1:0]),
    .rd_addr(current_run_r[IDX_W-1:0]),
    .rd_data(rd_val)
  );

  // Evaluate a fetch against the cached run.
  always_comb begin
    eval      = EV_DONE;
    res_valid = 1'b0;
    res_val   = '0;
    if (elements_left_r != '0) begin
      if (range_flag_r) begin
        // past the data: repeat the last run's value
        if (runs_loaded_r != '0) begin
          if (cache_vld_r) begin
            res_valid = 1'b1;
            res_val   = cur_val_r;
          end else begin
            eval = EV_MISS;
          end
        end
      end else if (current_run_r < runs_loaded_r) begin
        if (!cache_vld_r) begin
          eval = EV_MISS;
        end else if (offset_r >= cur_len_r) begin
          eval = EV_SKIP;
        end else begin
          res_valid = 1'b1;
          res_val   = cur_val_r;
        end
      end
    end
  end

  assign emit = cmd_i.fetch_step && (eval == EV_DONE);

  always_comb begin
    runs_loaded_nxt   = runs_loaded_r;
    current_run_nxt   = current_run_r;
    offset_nxt        = offset_r;
    elements_left_nxt = elements_left_r;
    range_flag_nxt    = range_flag_r;
    overflow_flag_nxt = overflow_flag_r;
    cache_vld_nxt     = cache_vld_r;
    pos_nxt           = pos_r;
    target_nxt        = target_r;
    cur_len_nxt       = cur_len_r;
    cur_val_nxt       = cur_val_r;
    out_value_nxt     = out_value_r;
    out_valid_res_nxt = out_valid_res_r;
    out_last_nxt      = out_last_r;
    out_range_nxt     = out_range_r;
    out_ovf_nxt       = out_ovf_r;
    out_valid_nxt     = out_valid_r && out_stall;

    if (cmd_i.clear) begin
      runs_loaded_nxt   = '0;
      current_run_nxt   = '0;
      offset_nxt        = '0;
      elements_left_nxt = '0;
      range_flag_nxt    = 1'b0;
      overflow_flag_nxt = 1'b0;
      cache_vld_nxt     = 1'b0;
    end

    if (cmd_i.append) begin
      if (!table_full) begin
        runs_loaded_nxt = runs_loaded_r + CNT_W'(1);
      end else begin
        overflow_flag_nxt = 1'b1;
      end
    end

    if (cmd_i.seek_init) begin
      elements_left_nxt = EL_W'(VECTOR_SIZE);
      current_run_nxt   = '0;
      offset_nxt        = '0;
      cache_vld_nxt     = 1'b0;
      pos_nxt           = '0;
      target_nxt        = ACC_W'(in_vector_index) * ACC_W'(VECTOR_SIZE);
      if (runs_loaded_r == '0) begin
        range_flag_nxt = 1'b1;
      end
    end

    if (cmd_i.seek_step) begin
      if (seek_found) begin
        offset_nxt     = LEN_W'(target_r - pos_r);
        range_flag_nxt = 1'b0;
        cache_vld_nxt  = 1'b1;
        cur_len_nxt    = rd_len;
        cur_val_nxt    = rd_val;
      end else if (seek_end) begin
        // stay on the last run
        range_flag_nxt = 1'b1;
        offset_nxt     = '0;
      end else begin
        pos_nxt         = pos_sum;
        current_run_nxt = run_inc;
      end
    end

    if (cmd_i.cache_fill) begin
      cache_vld_nxt = 1'b1;
      cur_len_nxt   = rd_len;
      cur_val_nxt   = rd_val;
    end

    if (cmd_i.fetch_step) begin
      case (eval)
        EV_SKIP: begin
          current_run_nxt = run_inc;
          offset_nxt      = '0;
          cache_vld_nxt   = 1'b0;
        end
        EV_DONE: begin
          out_valid_nxt     = 1'b1;
          out_value_nxt     = OUT_VALUE_W'(res_val);
          out_valid_res_nxt = res_valid;
          out_last_nxt      = (elements_left_r == EL_W'(1));
          out_range_nxt     = range_flag_r;
          out_ovf_nxt       = overflow_flag_r;
          if (elements_left_r != '0) begin
            elements_left_nxt = elements_left_r - EL_W'(1);
          end
          if (res_valid && !range_flag_r) begin
            offset_nxt = offset_r + LEN_W'(1);
          end
        end
        default: begin
          out_valid_nxt = out_valid_r && out_stall;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      runs_loaded_r   <= '0;
      current_run_r   <= '0;
      offset_r        <= '0;
      elements_left_r <= '0;
      range_flag_r    <= 1'b0;
      overflow_flag_r <= 1'b0;
      cache_vld_r     <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      runs_loaded_r   <= runs_loaded_nxt;
      current_run_r   <= current_run_nxt;
      offset_r        <= offset_nxt;
      elements_left_r <= elements_left_nxt;
      range_flag_r    <= range_flag_nxt;
      overflow_flag_r <= overflow_flag_nxt;
      cache_vld_r     <= cache_vld_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r           <= pos_nxt;
    target_r        <= target_nxt;
    cur_len_r       <= cur_len_nxt;
    cur_val_r       <= cur_val_nxt;
    out_value_r     <= out_value_nxt;
    out_valid_res_r <= out_valid_res_nxt;
    out_last_r      <= out_last_nxt;
    out_range_r     <= out_range_nxt;
    out_ovf_r       <= out_ovf_nxt;
  end

  assign sts_o.slot_free   = slot_free;
  assign sts_o.eval        = eval;
  assign sts_o.seek_found  = seek_found;
  assign sts_o.seek_end    = seek_end;
  assign sts_o.table_empty = (runs_loaded_r == '0);

  assign out_valid          = out_valid_r;
  assign out_value          = out_value_r;
  assign out_valid_res      = out_valid_res_r;
  assign out_last           = out_last_r;
  assign out_out_of_range   = out_range_r;
  assign out_table_overflow = out_ovf_r;

  `RVRD_ASSERT_IMPL(a_cache_in_table, cache_vld_r, current_run_r < runs_loaded_r)
  `RVRD_ASSERT_IMPL(a_runs_bounded, 1'b1, runs_loaded_r <= CNT_W'(MAX_RUNS))
  `RVRD_ASSERT_NEXT(a_last_on_final, emit && elements_left_r == EL_W'(1), out_valid_r && out_last_r)

endmodule

### rtl/rle_vector_range_decoder_unit.sv
// Top level of the run-length vector range decoder.
// Depends on rvrd_pkg, rvrd_ctrl and rvrd_datapath.
`timescale 1ns / 1ps

// Runs (length, value) are appended one per transaction into two run
// memories of MAX_RUNS entries; start seeks the run that holds element
// vector_index * VECTOR_SIZE, and each fetch then returns one element of that
// vector. While fetches stay inside the cached current run and the output is
// not stalled, a fetch stream delivers one value per cycle. Crossing into
// the next run goes through skip, registered run memory read, cache reload
// and evaluate steps, and each zero-length run passed over adds a miss,
// reload and skip. The first fetch after a start that lands past the data,
// or after runs are appended to an exhausted vector, waits for a cache
// reload. A fetch also waits while the previous result sits stalled in the
// output register. Start walks the runs from the first, with a registered
// run length memory read and a check for each run examined; on an empty
// table it does not walk. The run memories are not cleared at reset; only
// entries below the loaded count are ever read.
module rle_vector_range_decoder_unit
  import rvrd_pkg::*;
#(
  parameter int MAX_RUNS    = MAX_RUNS_DEF,
  parameter int VECTOR_SIZE = VECTOR_SIZE_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CMD_W-1:0]       in_command,
  input  logic [LEN_W-1:0]       in_run_length,
  input  logic [OUT_VALUE_W-1:0] in_run_value,
  input  logic [VINDEX_W-1:0]    in_vector_index,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUT_VALUE_W-1:0] out_value,
  output logic                   out_valid_res,
  output logic                   out_last,
  output logic                   out_out_of_range,
  output logic                   out_table_overflow
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  rvrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_command(in_command),
    .in_stall  (in_stall),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rvrd_datapath #(
    .MAX_RUNS   (MAX_RUNS),
    .VECTOR_SIZE(VECTOR_SIZE),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_run_length     (in_run_length),
    .in_run_value      (in_run_value),
    .in_vector_index   (in_vector_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value         (out_value),
    .out_valid_res     (out_valid_res),
    .out_last          (out_last),
    .out_out_of_range  (out_out_of_range),
    .out_table_overflow(out_table_overflow)
  );

endmodule

### sim/rle_vector_range_decoder_unit_tb.sv
// Self-checking testbench for rle_vector_range_decoder_unit.
// Depends on rvrd_pkg and the decoder RTL; predicts every fetch result in
// SystemVerilog and compares it with the block's output, field by field.
`timescale 1ns / 1ps

module rle_vector_range_decoder_unit_tb;
  import rvrd_pkg::*;

  localparam int MAX_RUNS     = MAX_RUNS_DEF;
  localparam int VECTOR_SIZE  = VECTOR_SIZE_DEF;
  localparam int VALUE_WIDTH  = VALUE_WIDTH_DEF;
  localparam logic [63:0] VALUE_MASK =
    (VALUE_WIDTH >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << VALUE_WIDTH) - 64'd1);
  localparam int RANDOM_ITEMS = 1650;

  typedef struct {
    logic [63:0] value;
    logic        valid_res;
    logic        last;
    logic        out_of_range;
    logic        table_overflow;
  } decoded_elem_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [CMD_W-1:0]       in_command;
  logic [LEN_W-1:0]       in_run_length;
  logic [OUT_VALUE_W-1:0] in_run_value;
  logic [VINDEX_W-1:0]    in_vector_index;
  logic                   out_valid;
  logic                   out_stall;
  logic [OUT_VALUE_W-1:0] out_value;
  logic                   out_valid_res;
  logic                   out_last;
  logic                   out_out_of_range;
  logic                   out_table_overflow;

  // Predicted decoder state
  logic [31:0]  run_len_tbl [MAX_RUNS];
  logic [63:0]  run_val_tbl [MAX_RUNS];
  int unsigned  runs_held;
  int unsigned  seek_run;
  logic [31:0]  seek_offset;
  int unsigned  elems_left;
  bit           past_end_flag;
  bit           dropped_flag;

  decoded_elem_t pending_elems[$];
  int            mismatches;
  int            items_sent;
  int            burst_left;

  rle_vector_range_decoder_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_run_length      (in_run_length),
    .in_run_value       (in_run_value),
    .in_vector_index    (in_vector_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_value          (out_value),
    .out_valid_res      (out_valid_res),
    .out_last           (out_last),
    .out_out_of_range   (out_out_of_range),
    .out_table_overflow (out_table_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TIMEOUT: %0d results still outstanding", pending_elems.size());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] rand_run_len();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1, 2, 3: return $urandom_range(1, 4);
      4, 5:    return $urandom_range(1, 64);
      6, 7:    return $urandom_range(64, 1500);
      8:       return $urandom_range(1000, 5000);
      default: return $urandom;
    endcase
  endfunction

  // Advance the predicted decoder by one accepted transaction.
  function automatic void decode_step(command_t cmd, logic [31:0] len, logic [63:0] val,
                                      logic [21:0] vidx);
    decoded_elem_t elem;
    logic [63:0]   target;
    logic [63:0]   pos;
    bit            found;
    elem = '{value: '0, valid_res: 1'b0, last: 1'b0, out_of_range: 1'b0,
             table_overflow: 1'b0};
    case (cmd)
      CMD_CLEAR: begin
        runs_held     = 0;
        seek_run      = 0;
        seek_offset   = '0;
        elems_left    = 0;
        past_end_flag = 1'b0;
        dropped_flag  = 1'b0;
      end
      CMD_APPEND: begin
        if (runs_held < MAX_RUNS) begin
          run_len_tbl[runs_held] = len;
          run_val_tbl[runs_held] = val & VALUE_MASK;
          runs_held++;
        end else begin
          dropped_flag = 1'b1;
        end
      end
      CMD_START: begin
        target     = 64'(vidx) * 64'(VECTOR_SIZE);
        pos        = '0;
        found      = 1'b0;
        elems_left = VECTOR_SIZE;
        for (int i = 0; i < runs_held && !found; i++) begin
          if (pos + 64'(run_len_tbl[i]) > target) begin
            seek_run    = i;
            seek_offset = 32'(target - pos);
            found       = 1'b1;
          end else begin
            pos += 64'(run_len_tbl[i]);
          end
        end
        past_end_flag = !found;
        if (!found) begin
          seek_offset = '0;
          seek_run    = (runs_held > 0) ? runs_held - 1 : 0;
        end
      end
      CMD_FETCH: begin
        if (elems_left > 0) begin
          if (past_end_flag) begin
            // Past the data: repeat the last run seen at seek time
            if (runs_held > 0 && seek_run < runs_held) begin
              elem.value     = run_val_tbl[seek_run];
              elem.valid_res = 1'b1;
            end
          end else begin
            // Skip exhausted and zero-length runs
            while (seek_run < runs_held && seek_offset >= run_len_tbl[seek_run]) begin
              seek_run++;
              seek_offset = '0;
            end
            if (seek_run < runs_held) begin
              elem.value     = run_val_tbl[seek_run];
              elem.valid_res = 1'b1;
              seek_offset++;
            end
          end
          elems_left--;
          elem.last = (elems_left == 0);
        end
        elem.out_of_range   = past_end_flag;
        elem.table_overflow = dropped_flag;
        pending_elems.insert(pending_elems.size(), elem);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    decoded_elem_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_elems.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value %h", $time, out_value);
        mismatches++;
      end else begin
        want = pending_elems.pop_front();
        check_field("value", want.value, out_value);
        check_field("valid_res", 64'(want.valid_res), 64'(out_valid_res));
        check_field("last", 64'(want.last), 64'(out_last));
        check_field("out_of_range", 64'(want.out_of_range), 64'(out_out_of_range));
        check_field("table_overflow", 64'(want.table_overflow), 64'(out_table_overflow));
      end
    end
  end

  // Receiver: stall probability changes from stretch to stretch
  initial begin : stall_pattern
    int stall_pct;
    out_stall <= 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      repeat ($urandom_range(16, 160)) begin
        @(posedge clk);
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Called right after a rising edge; returns right after the accepting edge, or after an idle gap that follows it.
  task automatic send_item(command_t cmd, logic [31:0] len, logic [63:0] val,
                           logic [21:0] vidx);
    int gap;
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_run_length   <= len;
    in_run_value    <= val;
    in_vector_index <= vidx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_step(cmd, len, val, vidx);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic do_clear();
    send_item(CMD_CLEAR, $urandom, rand64(), 22'($urandom));
  endtask

  task automatic do_append(logic [31:0] len, logic [63:0] val);
    send_item(CMD_APPEND, len, val, 22'($urandom));
  endtask

  task automatic do_start(logic [21:0] vidx);
    send_item(CMD_START, $urandom, rand64(), vidx);
  endtask

  task automatic do_fetch(int count);
    repeat (count) send_item(CMD_FETCH, $urandom, rand64(), 22'($urandom));
  endtask

  // Hold the sender until every predicted result has been seen.
  task automatic hold_until_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_elems.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_table();
    do_fetch(1);
    do_start(22'd0);
    do_fetch(2);
    // Run appended after a seek on an empty table becomes visible
    do_append(32'd1, 64'h0123_4567_89AB_CDEF);
    do_fetch(1);
    do_start(22'h3F_FFFF);
    do_fetch(1);
    hold_until_drained();
  endtask

  task automatic test_extreme_runs();
    do_clear();
    do_append(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    do_append(32'd0, 64'd0);
    do_start(22'h3F_FFFF);
    do_fetch(2);
    do_start(22'd0);
    do_fetch(1);
    do_clear();
    do_append(32'h8000_0000, 64'h5555_5555_5555_5555);
    do_append(32'hFFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA);
    do_start(22'h3F_FFFF);
    do_fetch(2);
    // Start exactly on the run boundary
    do_start(22'h20_0000);
    do_fetch(1);
    hold_until_drained();
  endtask

  task automatic test_zero_length_runs();
    do_clear();
    do_append(32'd0, 64'h1111_1111_1111_1111);
    do_append(32'd2, 64'h2222_2222_2222_2222);
    do_append(32'd0, 64'h3333_3333_3333_3333);
    do_append(32'd1, 64'h4444_4444_4444_4444);
    do_start(22'd0);
    do_fetch(4);
    // Append mid-vector: later fetches pick up the new run
    do_append(32'd3, 64'h5555_AAAA_5555_AAAA);
    do_fetch(2);
    do_start(22'd0);
    do_fetch(1);
    do_start(22'd1);
    do_fetch(2);
    hold_until_drained();
  endtask

  task automatic test_full_table();
    do_clear();
    // Mostly zero-length runs, so one vector walks off the end of a full table
    for (int i = 0; i < MAX_RUNS; i++)
      do_append((i % 8 == 0) ? 32'd1 : 32'd0, rand64());
    do_append(32'd5, rand64());
    do_fetch(1);
    do_start(22'd0);
    do_fetch(VECTOR_SIZE + 1);
    do_start(22'd1);
    do_fetch(3);
    do_clear();
    do_fetch(1);
    hold_until_drained();
  endtask

  task automatic test_random_streams();
    int stop_at;
    int n_append;
    int n_fetch;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if (runs_held > 200 || $urandom_range(0, 5) == 0)
        do_clear();
      n_append = (runs_held == 0) ? $urandom_range(1, 6) : $urandom_range(0, 4);
      repeat (n_append) do_append(rand_run_len(), rand64());
      if ($urandom_range(0, 4) == 0)
        do_start(22'($urandom));
      else
        do_start(22'($urandom_range(0, 3)));
      // Occasionally run the vector to its end and beyond
      if ($urandom_range(0, 59) == 0)
        n_fetch = elems_left + $urandom_range(0, 2);
      else
        n_fetch = $urandom_range(1, 40);
      for (int k = 0; k < n_fetch; k++) begin
        if ($urandom_range(0, 19) == 0)
          send_item(command_t'($urandom_range(0, 3)), rand_run_len(), rand64(),
                    22'($urandom));
        else
          do_fetch(1);
      end
    end
    hold_until_drained();
  endtask

  initial begin
    mismatches = 0;
    items_sent = 0;
    burst_left = 0;
    runs_held     = 0;
    seek_run      = 0;
    seek_offset   = '0;
    elems_left    = 0;
    past_end_flag = 1'b0;
    dropped_flag  = 1'b0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_command      <= CMD_CLEAR;
    in_run_length   <= '0;
    in_run_value    <= '0;
    in_vector_index <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_extreme_runs();
    test_zero_length_runs();
    test_full_table();
    test_random_streams();

    repeat (64) @(posedge clk);
    if (mismatches == 0 && pending_elems.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
